>>> design/dtq_pkg.sv
// ----------------------------------------------------------------------------
// dtq_pkg: shared types and constants for the deadline timer queue
// Request and result payloads, result codes, and the command/status bundles
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam int unsigned TimeW  = 48;
  localparam int unsigned IdW    = 32;
  localparam int unsigned TagW   = 16;
  localparam int unsigned DelayW = 32;

  // Saturation value of the millisecond counter and of every deadline
  localparam logic [TimeW-1:0] TIME_MAX = {TimeW{1'b1}};

  // Most expired results that one tick may report
  localparam int unsigned RESULT_CAP = 16;
  localparam int unsigned CntW       = $clog2(RESULT_CAP + 1);

  typedef enum logic {
    CMD_REG  = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_REG = 2'd0,
    KIND_EXP = 2'd1,
    KIND_REJ = 2'd2
  } kind_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [DelayW-1:0] delay_ms;
    logic [TagW-1:0]   user_tag;
    logic              notify;
  } in_t;

  typedef struct packed {
    kind_e           kind;
    logic [IdW-1:0]  timer_id;
    logic [TagW-1:0] tag_out;
    logic            last;
  } out_t;

  // One stored timer
  typedef struct packed {
    logic [TimeW-1:0] deadline;
    logic [IdW-1:0]   id;
    logic [TagW-1:0]  tag;
    logic             notify;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic load_req;    // capture the incoming request
    logic tick;        // advance time, restart the result count
    logic start_scan;  // begin a search for the earliest due timer
    logic reg_commit;  // store the captured timer or reject it
    logic pop;         // remove the best timer found by the last scan
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;
    logic scan_done;
    logic best_found;
    logic best_notify;
    logic cap_last;    // the next reported expiry reaches the cap
    logic out_free;
  } dp_sts_t;

endpackage

>>> design/dtq_ctrl.sv
// ----------------------------------------------------------------------------
// dtq_ctrl: sequencer of the deadline timer queue
// Accepts one request at a time and steps the datapath through registration
// or through the scan/pop rounds of a tick.
// ----------------------------------------------------------------------------
module dtq_ctrl
  import dtq_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  cmd_e    in_cmd_i,
  output logic    in_stall_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_REG  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_POP  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Take a request only while idle
  assign in_stall_o = (state_q != ST_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_cmd_i == CMD_TICK) begin
            cmd_o.tick       = 1'b1;
            cmd_o.start_scan = 1'b1;
            state_d          = ST_SCAN;
          end else begin
            cmd_o.load_req = 1'b1;
            state_d        = ST_REG;
          end
        end
      end
      ST_REG: begin
        if (sts_i.out_free) begin
          cmd_o.reg_commit = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = ST_POP;
        end
      end
      ST_POP: begin
        if (!sts_i.best_found) begin
          state_d = ST_IDLE;
        end else if (!sts_i.best_notify) begin
          // drop silently and look for the next one
          cmd_o.pop        = 1'b1;
          cmd_o.start_scan = 1'b1;
          state_d          = ST_SCAN;
        end else if (sts_i.out_free) begin
          cmd_o.pop = 1'b1;
          // stop at the cap, else keep scanning so due silent timers leave too
          if (sts_i.cap_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.start_scan = 1'b1;
            state_d          = ST_SCAN;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> design/dtq_datapath.sv
// ----------------------------------------------------------------------------
// dtq_datapath: time counter, timer store and result register
// Holds the timers in a memory scanned one slot per cycle, keeps the best
// due candidate, and drives the registered result port.
// ----------------------------------------------------------------------------
module dtq_datapath
  import dtq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  in_t     in_data_i,
  input  dp_cmd_t cmd_i,
  output dp_sts_t sts_o,
  input  logic    out_stall_i,
  output logic    out_valid_o,
  output out_t    out_data_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LastSlot = AW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] CapLast = CntW'(RESULT_CAP - 1);

  logic [TimeW-1:0]       now_q;
  logic [IdW-1:0]         next_id_q;
  logic [QUEUE_DEPTH-1:0] valid_q;
  in_t                    req_q;

  entry_t                 mem [QUEUE_DEPTH];
  entry_t                 rd_q;
  logic [AW-1:0]          rd_slot_q;
  logic [AW-1:0]          scan_addr_q;
  logic                   scan_act_q;
  logic                   cmp_vld_q;

  logic                   best_found_q;
  logic [AW-1:0]          best_slot_q;
  entry_t                 best_q;
  logic [NW-1:0]          ncnt_q;
  logic [CntW-1:0]        emit_cnt_q;

  logic                   out_valid_q;
  out_t                   out_q, out_d;

  logic                   full;
  logic [AW-1:0]          free_slot;
  logic [TimeW:0]         dl_sum;
  logic [TimeW-1:0]       dl_new;
  logic                   cand_due, cand_better;
  logic                   pop_last, out_free, load_out, store;

  // Lowest free slot
  always_comb begin
    free_slot = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_slot = AW'(i);
      end
    end
  end

  assign full  = &valid_q;
  assign store = cmd_i.reg_commit && !full;

  // Saturating deadline
  assign dl_sum = (TimeW+1)'(now_q) + (TimeW+1)'(req_q.delay_ms);
  assign dl_new = dl_sum[TimeW] ? TIME_MAX : dl_sum[TimeW-1:0];

  // Compare the slot read last cycle against the running best
  assign cand_due    = cmp_vld_q && valid_q[rd_slot_q] && (rd_q.deadline <= now_q);
  assign cand_better = !best_found_q || (rd_q.deadline < best_q.deadline) ||
                       ((rd_q.deadline == best_q.deadline) && (rd_q.id < best_q.id));

  assign pop_last = (emit_cnt_q == CapLast) || (ncnt_q == NW'(1));
  assign out_free = !out_valid_q || !out_stall_i;
  assign load_out = cmd_i.reg_commit || (cmd_i.pop && best_q.notify);

  // Result to load
  always_comb begin
    out_d = '0;
    if (cmd_i.reg_commit) begin
      if (full) begin
        out_d.kind = KIND_REJ;
      end else begin
        out_d.kind     = KIND_REG;
        out_d.timer_id = next_id_q;
      end
      out_d.last = 1'b1;
    end else begin
      out_d.kind     = KIND_EXP;
      out_d.timer_id = best_q.id;
      out_d.tag_out  = best_q.tag;
      out_d.last     = pop_last;
    end
  end

  // Timer store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (store) begin
      mem[free_slot] <= '{deadline: dl_new, id: next_id_q,
                          tag: req_q.user_tag, notify: req_q.notify};
    end
    rd_q      <= mem[scan_addr_q];
    rd_slot_q <= scan_addr_q;
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= in_data_i;
    end
    if (cand_due && cand_better) begin
      best_q      <= rd_q;
      best_slot_q <= rd_slot_q;
    end
    if (load_out) begin
      out_q <= out_d;
    end
  end

  // Time, ids and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q      <= '0;
      next_id_q  <= IdW'(1);
      valid_q    <= '0;
      emit_cnt_q <= '0;
    end else begin
      if (cmd_i.tick) begin
        if (now_q != TIME_MAX) begin
          now_q <= now_q + TimeW'(1);
        end
        emit_cnt_q <= '0;
      end
      if (store) begin
        valid_q[free_slot] <= 1'b1;
        next_id_q <= (next_id_q == {IdW{1'b1}}) ? IdW'(1) : next_id_q + IdW'(1);
      end
      if (cmd_i.pop) begin
        valid_q[best_slot_q] <= 1'b0;
        if (best_q.notify) begin
          emit_cnt_q <= emit_cnt_q + CntW'(1);
        end
      end
    end
  end

  // Scan sequencing and best tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_addr_q  <= '0;
      scan_act_q   <= 1'b0;
      cmp_vld_q    <= 1'b0;
      best_found_q <= 1'b0;
      ncnt_q       <= '0;
    end else begin
      cmp_vld_q <= scan_act_q;
      if (cmd_i.start_scan) begin
        scan_addr_q  <= '0;
        scan_act_q   <= 1'b1;
        best_found_q <= 1'b0;
        ncnt_q       <= '0;
      end else begin
        if (scan_act_q) begin
          if (scan_addr_q == LastSlot) begin
            scan_act_q <= 1'b0;
          end else begin
            scan_addr_q <= scan_addr_q + AW'(1);
          end
        end
        if (cand_due) begin
          if (rd_q.notify) begin
            ncnt_q <= ncnt_q + NW'(1);
          end
          if (cand_better) begin
            best_found_q <= 1'b1;
          end
        end
      end
    end
  end

  // Result register handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.full        = full;
  assign sts_o.scan_done   = !scan_act_q && !cmp_vld_q;
  assign sts_o.best_found  = best_found_q;
  assign sts_o.best_notify = best_q.notify;
  assign sts_o.cap_last    = (emit_cnt_q == CapLast);
  assign sts_o.out_free    = out_free;

  // Never overwrite a result that has not been taken
  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> out_free)
    else $error("result register loaded while occupied");

  // The id counter skips zero
  a_id_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_id_q != '0)
    else $error("next id is zero");

  // A pop frees exactly one occupied slot
  a_pop_frees : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |=> ($countones(valid_q) + 1) == $past($countones(valid_q)))
    else $error("pop did not free one slot");

  // One tick never reports more than the cap
  a_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_cnt_q <= CntW'(RESULT_CAP))
    else $error("expired result count beyond cap");

endmodule

>>> design/deadline_timer_queue.sv
// A register request stores a timer due at now + delay_ms (saturated) and
// answers with its id, or with a reject when all QUEUE_DEPTH slots are
// taken. A tick request advances the millisecond counter and then runs
// rounds of a search over the timer memory, one slot per cycle through its
// single read port: each round removes the earliest due timer (ties by
// smaller id, then lower slot), and the rounds go on until one finds
// nothing due or the tick stops at the sixteenth reported expiry.
// Timers without notify leave without a result; a tick with nothing to report
// gives no result. The last result of each request has last set. Further
// requests stall until the current one is done; a waiting result does not
// block work on the next request until another result must be loaded.
// ----------------------------------------------------------------------------
// deadline_timer_queue: millisecond timer queue, top level
// Joins the sequencer and the datapath behind valid/stall request and result
// channels.
// ----------------------------------------------------------------------------
module deadline_timer_queue
  import dtq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // Sequencer
  dtq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_data_i.cmd),
    .in_stall_o (in_stall_o),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  // Timer store and result register
  dtq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

>>> dv/deadline_timer_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_timer_queue_tb: self-checking bench for the millisecond timer queue
// Walks a directed table (first ids, zero and full-range delays, silent drops,
// queue full, a tick that drains the due timers of a full queue), then random register and tick
// requests. Each accepted request goes through a local timer predictor, and
// each accepted result is compared in order. Both channels idle at random.
// ----------------------------------------------------------------------------
module deadline_timer_queue_tb;
  import dtq_pkg::*;

  localparam int unsigned QUEUE_DEPTH    = 16;
  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned RESET_CYCLES   = 8;
  localparam int unsigned RAND_REQUESTS  = 480;
  localparam int unsigned DIR_ROWS       = 24;
  // One scan round per removed timer, plus the round that finds nothing
  localparam int unsigned DRAIN_CYCLES   = 2 * (RESULT_CAP + 1) * (QUEUE_DEPTH + 3);
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned MAX_REPORTS    = 10;

  // Receiver stall patterns
  typedef enum int {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_e;

  // One directed request; a typed result replaces the predicted one
  typedef struct {
    in_t  req;
    logic typed;
    out_t res;
  } dir_row_t;

  localparam out_t NO_TYPED = '0;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  // Typed result that travels with the request being offered
  logic drv_typed = 1'b0;
  out_t drv_res   = '0;

  // Timer predictor state
  logic [TimeW-1:0] clock_ms;
  logic [IdW-1:0]   next_timer_id;
  logic             slot_busy  [QUEUE_DEPTH];
  entry_t           slot_entry [QUEUE_DEPTH];
  out_t             step_results[$];

  out_t pending_results[$];
  int   fail_count  = 0;
  int   idle_cycles = 0;
  int   burst_left  = 0;

  rx_mode_e    rx_mode      = RX_FREE;
  int          rx_mode_left = 0;
  logic [2:0]  rx_phase     = '0;

  dir_row_t directed_rows [DIR_ROWS] = '{
    // first ids after reset, field extremes, a silent drop
    '{'{CMD_REG,  32'h0000_0000, 16'hFFFF, 1'b1}, 1'b1, '{KIND_REG, 32'd1, 16'h0, 1'b1}},
    '{'{CMD_REG,  32'hFFFF_FFFF, 16'h0000, 1'b1}, 1'b1, '{KIND_REG, 32'd2, 16'h0, 1'b1}},
    '{'{CMD_REG,  32'h0000_0001, 16'h1234, 1'b0}, 1'b1, '{KIND_REG, 32'd3, 16'h0, 1'b1}},
    '{'{CMD_REG,  32'h0000_0000, 16'hA5A5, 1'b1}, 1'b1, '{KIND_REG, 32'd4, 16'h0, 1'b1}},
    '{'{CMD_TICK, 32'h0000_0000, 16'h0000, 1'b0}, 1'b0, NO_TYPED},
    // tick with nothing due and all payload bits set
    '{'{CMD_TICK, 32'hFFFF_FFFF, 16'hFFFF, 1'b1}, 1'b0, NO_TYPED},
    // fill the queue; zero delays land a tick earlier than higher ids
    '{'{CMD_REG,  32'h0000_0001, 16'h0101, 1'b1}, 1'b0, NO_TYPED},
    '{'{CMD_REG,  32'h0000_0001, 16'h0102, 1'b1}, 1'b0, NO_TYPED},
    '{'{CMD_REG,  32'h0000_0001, 16'h0103, 1'b0}, 1'b0, NO_TYPED},
    '{'{CMD_REG,  32'h0000_0001, 16'h0104, 1'b1}, 1'b0, NO_TYPED},
    '{'{CMD_REG,  32'h0000_0000, 16'h0105, 1'b1}, 1'b0, NO_TYPED},
    '{'{CMD_REG,  32'h0000_0001, 16'h0106, 1'b1}, 1'b0, NO_TYPED},
    '{'{CMD_REG,  32'h0000_0001, 16'h0107, 1'b0}, 1'b0, NO_TYPED},
    '{'{CMD_REG,  32'h0000_0001, 16'h0108, 1'b1}, 1'b0, NO_TYPED},
    '{'{CMD_REG,  32'h0000_0001, 16'h0109, 1'b1}, 1'b0, NO_TYPED},
    '{'{CMD_REG,  32'h0000_0001, 16'h010A, 1'b1}, 1'b0, NO_TYPED},
    '{'{CMD_REG,  32'h0000_0000, 16'h010B, 1'b1}, 1'b0, NO_TYPED},
    '{'{CMD_REG,  32'h0000_0001, 16'h010C, 1'b1}, 1'b0, NO_TYPED},
    '{'{CMD_REG,  32'h0000_0001, 16'h010D, 1'b1}, 1'b0, NO_TYPED},
    '{'{CMD_REG,  32'h0000_0001, 16'h010E, 1'b0}, 1'b0, NO_TYPED},
    '{'{CMD_REG,  32'h0000_0000, 16'h010F, 1'b1}, 1'b0, NO_TYPED},
    // queue full
    '{'{CMD_REG,  32'h0000_0000, 16'hBEEF, 1'b1}, 1'b1, '{KIND_REJ, 32'd0, 16'h0, 1'b1}},
    // drain everything that is due, then an empty tick
    '{'{CMD_TICK, 32'h0000_0000, 16'h0000, 1'b0}, 1'b0, NO_TYPED},
    '{'{CMD_TICK, 32'h0000_0000, 16'h0000, 1'b0}, 1'b0, NO_TYPED}
  };

  deadline_timer_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Apply one request to the timer state and collect the results it causes
  function automatic void step_timers(input in_t req);
    logic [TimeW:0] due_sum;
    int             free_slot;
    int             pick;
    int             n_exp;
    out_t           res;
    step_results.delete();
    if (req.cmd == CMD_REG) begin
      free_slot = -1;
      for (int s = QUEUE_DEPTH - 1; s >= 0; s--) begin
        if (!slot_busy[s]) free_slot = s;
      end
      if (free_slot < 0) begin
        res = '{kind: KIND_REJ, timer_id: '0, tag_out: '0, last: 1'b1};
      end else begin
        due_sum = (TimeW+1)'(clock_ms) + (TimeW+1)'(req.delay_ms);
        slot_busy[free_slot]           = 1'b1;
        slot_entry[free_slot].deadline = due_sum[TimeW] ? TIME_MAX : due_sum[TimeW-1:0];
        slot_entry[free_slot].id       = next_timer_id;
        slot_entry[free_slot].tag      = req.user_tag;
        slot_entry[free_slot].notify   = req.notify;
        res = '{kind: KIND_REG, timer_id: next_timer_id, tag_out: '0, last: 1'b1};
        // skip id 0 on wrap
        next_timer_id = next_timer_id + IdW'(1);
        if (next_timer_id == '0) next_timer_id = IdW'(1);
      end
      step_results.push_back(res);
    end else begin
      if (clock_ms != TIME_MAX) clock_ms = clock_ms + TimeW'(1);
      n_exp = 0;
      pick  = 0;
      // pop due timers, earliest deadline first, then smaller id, then lower slot
      while (n_exp < RESULT_CAP && pick >= 0) begin
        pick = -1;
        for (int s = 0; s < QUEUE_DEPTH; s++) begin
          if (slot_busy[s] && slot_entry[s].deadline <= clock_ms) begin
            if (pick < 0 || slot_entry[s].deadline < slot_entry[pick].deadline ||
                (slot_entry[s].deadline == slot_entry[pick].deadline &&
                 slot_entry[s].id < slot_entry[pick].id)) begin
              pick = s;
            end
          end
        end
        if (pick >= 0) begin
          slot_busy[pick] = 1'b0;
          if (slot_entry[pick].notify) begin
            res = '{kind: KIND_EXP, timer_id: slot_entry[pick].id,
                    tag_out: slot_entry[pick].tag, last: 1'b0};
            step_results.push_back(res);
            n_exp++;
          end
        end
      end
      if (n_exp > 0) begin
        res      = step_results.pop_back();
        res.last = 1'b1;
        step_results.push_back(res);
      end
    end
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("[%0t] %s", $realtime, msg);
  endfunction

  // Offer one request in bursts with random gaps, hold it until taken
  task automatic send_request(input in_t req, input logic typed, input out_t res);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    drv_typed  <= typed;
    drv_res    <= res;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Receiver stall: switch between patterns at random
  always @(negedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_e'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(32, 256);
    end
    rx_mode_left--;
    rx_phase = rx_phase + 3'd1;
    case (rx_mode)
      RX_FREE:  out_stall_i <= 1'b0;
      RX_LIGHT: out_stall_i <= ($urandom_range(0, 9) < 3);
      RX_HEAVY: out_stall_i <= ($urandom_range(0, 9) < 7);
      default:  out_stall_i <= (rx_phase < 3'd3);
    endcase
  end

  // Check results first so a stray result never pairs with a fresh request
  always @(posedge clk_i) begin : monitor
    out_t want;
    logic took;
    took = 1'b0;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      took = 1'b1;
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result kind=%0d id=%0d tag=%h last=%b",
                               out_data_o.kind, out_data_o.timer_id, out_data_o.tag_out,
                               out_data_o.last));
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.kind !== want.kind || out_data_o.timer_id !== want.timer_id ||
            out_data_o.tag_out !== want.tag_out || out_data_o.last !== want.last) begin
          note_failure($sformatf(
            "result mismatch: expected kind=%0d id=%0d tag=%h last=%b, %s",
            want.kind, want.timer_id, want.tag_out, want.last,
            $sformatf("got kind=%0d id=%0d tag=%h last=%b", out_data_o.kind,
                      out_data_o.timer_id, out_data_o.tag_out, out_data_o.last)));
        end
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      took = 1'b1;
      step_timers(in_data_i);
      if (drv_typed) begin
        pending_results.push_back(drv_res);
      end else begin
        foreach (step_results[k]) pending_results.push_back(step_results[k]);
      end
    end
    idle_cycles = took ? 0 : idle_cycles + 1;
  end

  // End the run when nothing moves on either channel for too long
  initial begin
    do @(posedge clk_i); while (idle_cycles < WATCHDOG_LIMIT);
    $display("watchdog: no request or result accepted for %0d cycles", WATCHDOG_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    in_t req;
    int  reg_pct;
    int  seg_left;
    int  pick;
    clock_ms      = '0;
    next_timer_id = IdW'(1);
    for (int s = 0; s < QUEUE_DEPTH; s++) slot_busy[s] = 1'b0;
    seg_left = 0;
    reg_pct  = 50;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      send_request(directed_rows[r].req, directed_rows[r].typed, directed_rows[r].res);
    end

    // Random mix: segments lean toward filling or draining the queue, or stay balanced
    for (int i = 0; i < RAND_REQUESTS; i++) begin
      if (seg_left == 0) begin
        pick     = $urandom_range(0, 2);
        reg_pct  = (pick == 0) ? 20 : (pick == 1) ? 50 : 80;
        seg_left = $urandom_range(8, 40);
      end
      seg_left--;
      req.delay_ms = $urandom();
      req.user_tag = TagW'($urandom());
      req.notify   = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 99) < reg_pct) begin
        req.cmd = CMD_REG;
        // mostly short delays so timers expire within the run
        pick = $urandom_range(0, 63);
        if (pick >= 8) begin
          req.delay_ms = $urandom_range(0, 12);
        end else if (pick > 0) begin
          req.delay_ms = $urandom_range(0, 300);
        end
      end else begin
        req.cmd = CMD_TICK;
      end
      send_request(req, 1'b0, NO_TYPED);
    end
    in_valid_i <= 1'b0;

    // Wait for every expected result, then let a late stray show up
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
design/dtq_pkg.sv
design/dtq_ctrl.sv
design/dtq_datapath.sv
design/deadline_timer_queue.sv
dv/deadline_timer_queue_tb.sv
